/* rtl/core/stfp_pkg.sv */
// shared constants, types and rule tables of the fuzzy pi reference generator
`default_nettype none
package stfp_pkg;

  localparam int NumTerms       = 7;
  localparam int ErrorWidthDef  = 16;
  localparam int GRADE_W        = 13;
  localparam int ONE_Q12        = 4096;
  localparam int BP1            = 768;
  localparam int BP2            = 1536;
  localparam int BP3            = 3072;

  // accumulator and divider widths, fixed by grade and register widths
  localparam int W_W     = 2 * GRADE_W;
  localparam int DEN_W   = 30;
  localparam int ANUM_W  = 33;
  localparam int SNUM_W  = 38;
  localparam int DIV_W   = 37;
  localparam int DIVQ_W  = 25;
  localparam int CNT_W   = 5;

  // configuration register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;
  localparam logic [CFG_IDX_W-1:0] CFG_ERR_GAIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_GAIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD     = 3'd4;

  localparam logic [15:0] ERR_GAIN_RST   = 16'd704;
  localparam logic [3:0]  ALPHA_GAIN_RST = 4'd1;
  localparam logic [7:0]  OUT_GAIN_RST   = 8'd20;
  localparam logic [22:0] REF_LIMIT_RST  = 23'd53248;
  localparam logic [7:0]  PERIOD_RST     = 8'd20;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] iters;
  } div_req_t;

  localparam logic [2:0] ALPHA_TAB [NumTerms][NumTerms] = '{
    '{3'd5, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd1},
    '{3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd1, 3'd1},
    '{3'd4, 3'd3, 3'd2, 3'd1, 3'd1, 3'd1, 3'd2},
    '{3'd3, 3'd2, 3'd1, 3'd1, 3'd1, 3'd2, 3'd3},
    '{3'd3, 3'd1, 3'd1, 3'd1, 3'd2, 3'd3, 3'd4},
    '{3'd1, 3'd1, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5},
    '{3'd1, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd5}
  };

  // step singleton in hundredths, rule index i+j-3 clamped to the term range
  function automatic logic signed [7:0] step_level(input logic [2:0] i, input logic [2:0] j);
    logic [3:0] k;
    logic signed [7:0] lv;
    k = {1'b0, i} + {1'b0, j};
    case (k)
      4'd4:    lv = -8'sd66;
      4'd5:    lv = -8'sd33;
      4'd6:    lv = 8'sd0;
      4'd7:    lv = 8'sd33;
      4'd8:    lv = 8'sd66;
      4'd0, 4'd1, 4'd2, 4'd3: lv = -8'sd100;
      default: lv = 8'sd100;
    endcase
    return lv;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/stfp_fuzz.sv */
// seven-term triangular fuzzifier, shared by error and error change
`default_nettype none
module stfp_fuzz #(
  parameter int IN_W = 25
) (
  input  logic signed [IN_W-1:0]                               value_i,
  output logic [stfp_pkg::NumTerms-1:0][stfp_pkg::GRADE_W-1:0] grades_o
);
  import stfp_pkg::*;

  localparam int NW = IN_W + 2;
  localparam logic signed [NW-1:0] B1 = NW'(BP1);
  localparam logic signed [NW-1:0] B2 = NW'(BP2);
  localparam logic signed [NW-1:0] B3 = NW'(BP3);

  // wide selects a 1536 span, else 768; divide by 3 through a reciprocal
  function automatic logic [GRADE_W-1:0] ramp(input logic signed [NW-1:0] num,
                                               input logic wide);
    logic signed [NW-1:0] den;
    logic [15:0] v;
    logic [31:0] p;
    logic [GRADE_W-1:0] g;
    den = wide ? B2 : B1;
    v = wide ? {2'b0, num[10:0], 3'b0} : {1'b0, num[10:0], 4'b0};
    p = {16'b0, v} * 32'd43691;
    if (num <= 0) begin
      g = '0;
    end else if (num >= den) begin
      g = GRADE_W'(ONE_Q12);
    end else begin
      g = p[29:17];
    end
    return g;
  endfunction

  function automatic logic [GRADE_W-1:0] lower(input logic [GRADE_W-1:0] a,
                                               input logic [GRADE_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  logic signed [NW-1:0] xs;
  assign xs = {{2{value_i[IN_W-1]}}, value_i};

  assign grades_o[0] = ramp(-(xs + B2), 1'b1);
  assign grades_o[1] = lower(ramp(xs + B3, 1'b1), ramp(-(xs + B1), 1'b0));
  assign grades_o[2] = lower(ramp(xs + B2, 1'b0), ramp(-xs, 1'b0));
  assign grades_o[3] = lower(ramp(xs + B1, 1'b0), ramp(B1 - xs, 1'b0));
  assign grades_o[4] = lower(ramp(xs, 1'b0), ramp(B2 - xs, 1'b0));
  assign grades_o[5] = lower(ramp(xs - B1, 1'b0), ramp(B3 - xs, 1'b1));
  assign grades_o[6] = ramp(xs - B2, 1'b1);

endmodule
`default_nettype wire

/* rtl/core/stfp_div.sv */
// iterative restoring divider, one quotient bit per cycle
`default_nettype none
module stfp_div #(
  parameter int DW = 37,
  parameter int QW = 25
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  stfp_pkg::div_req_t       req_i,
  input  logic [DW-1:0]            rem_init_i,
  input  logic [QW-1:0]            lo_i,
  input  logic [DW-1:0]            divisor_i,
  output logic                     busy_o,
  output logic                     done_o,
  output logic [QW-1:0]            quot_o
);
  import stfp_pkg::*;

  logic [DW-1:0]    rem_q, rem_d, dv_q;
  logic [QW-1:0]    lo_q, quot_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [DW:0]      trial, trial_sub;
  logic             ge;

  assign trial     = {rem_q, lo_q[QW-1]};
  assign ge        = trial >= {1'b0, dv_q};
  assign trial_sub = trial - {1'b0, dv_q};
  assign rem_d     = ge ? trial_sub[DW-1:0] : trial[DW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_W'(1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.iters;
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= rem_init_i;
      lo_q   <= lo_i;
      dv_q   <= divisor_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      lo_q   <= {lo_q[QW-2:0], 1'b0};
      quot_q <= {quot_q[QW-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule
`default_nettype wire

/* rtl/core/self_tuning_fuzzy_pi_controller.sv */
// top level: sequencer, rule accumulator and reference update of the fuzzy pi block
`default_nettype none
// Self-tuning fuzzy PI reference generator. Each accepted error word is one
// control tick. On a refresh tick (every refresh_period ticks) the error and
// the scaled error change are fuzzified into seven triangular grades, one
// value per cycle through a shared fuzzifier. Every tick then walks the 7x7
// rule base one rule per cycle through a single grade multiplier, divides
// for the tuning gain and for the reference step in one shared restoring
// divider (16 and 25 quotient bits), and updates the reference. A zero weight
// sum skips both divisions, a reference beyond the limit the step division. The
// input is stalled until the sequencer is back to idle. The result word sits
// in an output register, so the next tick is taken as soon as the sequencer is
// back to idle even if the result has not been taken. Configuration is written
// through a plain write port by the user while idle; the block does not enforce it.
module self_tuning_fuzzy_pi_controller #(
  parameter int ERROR_WIDTH = stfp_pkg::ErrorWidthDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [stfp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [stfp_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [ERROR_WIDTH-1:0]     error_value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [23:0]                reference_o,
  output logic [15:0]                       tuning_gain_o,
  output logic                              refreshed_o
);
  import stfp_pkg::*;

  localparam int CHG_W  = ERROR_WIDTH + 9;
  localparam int PROD_W = ERROR_WIDTH + 18;
  localparam int N1_W   = ANUM_W + 16;
  localparam int N2_W   = 62;
  localparam int PP_W   = 43;

  // sequencer codes
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CHG  = 4'd1;
  localparam logic [3:0] S_FUZE = 4'd2;
  localparam logic [3:0] S_FUZC = 4'd3;
  localparam logic [3:0] S_MAC  = 4'd4;
  localparam logic [3:0] S_AGO  = 4'd5;
  localparam logic [3:0] S_ADIV = 4'd6;
  localparam logic [3:0] S_MLO  = 4'd7;
  localparam logic [3:0] S_MHI  = 4'd8;
  localparam logic [3:0] S_DGO  = 4'd9;
  localparam logic [3:0] S_DDIV = 4'd10;
  localparam logic [3:0] S_FIN  = 4'd11;

  // configuration registers
  logic [15:0] ecg_q;
  logic [3:0]  ag_q;
  logic [7:0]  og_q;
  logic [22:0] lim_q;
  logic [7:0]  per_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ecg_q <= ERR_GAIN_RST;
      ag_q  <= ALPHA_GAIN_RST;
      og_q  <= OUT_GAIN_RST;
      lim_q <= REF_LIMIT_RST;
      per_q <= PERIOD_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ERR_GAIN:   ecg_q <= cfg_data_i[15:0];
        CFG_ALPHA_GAIN: ag_q  <= cfg_data_i[3:0];
        CFG_OUT_GAIN:   og_q  <= cfg_data_i[7:0];
        CFG_REF_LIMIT:  lim_q <= cfg_data_i[22:0];
        CFG_PERIOD:     per_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // controller state
  logic [3:0]                       state_q;
  logic [7:0]                       tick_q;
  logic signed [ERROR_WIDTH-1:0]    x_q, prev_q;
  logic signed [CHG_W-1:0]          change_q;
  logic                             refr_q;
  logic [GRADE_W-1:0]               eg_q [NumTerms];
  logic [GRADE_W-1:0]               cg_q [NumTerms];
  logic signed [23:0]               ref_q;

  // rule walk
  logic [2:0]                       i_q, j_q;
  logic                             issue_q, mac_v_q;
  logic [W_W-1:0]                   w_q;
  logic [2:0]                       a_q;
  logic signed [7:0]                s_q;
  logic [DEN_W-1:0]                 den_q;
  logic [ANUM_W-1:0]                anum_q;
  logic signed [SNUM_W-1:0]         snum_q;

  // tail arithmetic
  logic [15:0]                      alpha_q;
  logic [23:0]                      p_q;
  logic [N2_W-1:0]                  n2_q;
  logic signed [DIVQ_W:0]           delta_q;

  // output word
  logic                             out_valid_q;
  logic signed [23:0]               out_ref_q;
  logic [15:0]                      out_gain_q;
  logic                             out_refr_q;

  logic in_acc, out_take;
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_take   = out_valid_q && !out_stall_i;

  // tick counter and refresh decision
  logic [7:0] tick_inc, per_eff;
  logic       refr_now;
  assign tick_inc = tick_q + 8'd1;
  assign per_eff  = (per_q == 8'd0) ? 8'd1 : per_q;
  assign refr_now = tick_inc >= per_eff;

  // scaled error change, floor by arithmetic shift
  logic signed [ERROR_WIDTH:0] diff;
  logic signed [PROD_W-1:0]    prod;
  assign diff = $signed({x_q[ERROR_WIDTH-1], x_q}) - $signed({prev_q[ERROR_WIDTH-1], prev_q});
  assign prod = PROD_W'(diff) * $signed({{(PROD_W-17){1'b0}}, 1'b0, ecg_q});

  // shared fuzzifier
  logic signed [CHG_W-1:0]                 fuzz_in;
  logic [NumTerms-1:0][GRADE_W-1:0]        fuzz_g;
  assign fuzz_in = (state_q == S_FUZE) ? {{9{x_q[ERROR_WIDTH-1]}}, x_q} : change_q;

  stfp_fuzz #(.IN_W(CHG_W)) u_fuzz (
    .value_i  (fuzz_in),
    .grades_o (fuzz_g)
  );

  // rule weight and weighted terms
  logic [W_W-1:0]           w_d;
  logic [ANUM_W-1:0]        wa;
  logic signed [SNUM_W-1:0] ws;
  assign w_d = W_W'(eg_q[i_q]) * W_W'(cg_q[j_q]);
  assign wa  = ANUM_W'(w_q) * ANUM_W'(a_q);
  assign ws  = $signed({{(SNUM_W-W_W){1'b0}}, w_q}) * SNUM_W'(s_q);

  // divider operands
  logic [DIV_W-1:0]  d1, d2;
  logic [N1_W-1:0]   n1;
  logic [DIV_W-1:0]  sabs;
  logic [SNUM_W-1:0] sneg;
  logic [18:0]       half;
  logic [PP_W-1:0]   pp;
  assign d1   = DIV_W'(den_q) * DIV_W'(5);
  assign d2   = DIV_W'(den_q) * DIV_W'(100);
  assign n1   = (N1_W'(ag_q) * N1_W'(anum_q)) << 12;
  assign sneg = -snum_q;
  assign sabs = snum_q[SNUM_W-1] ? sneg[DIV_W-1:0] : snum_q[DIV_W-1:0];
  // one partial-product multiplier, low half then high half
  assign half = (state_q == S_MHI) ? {1'b0, sabs[DIV_W-1:19]} : sabs[18:0];
  assign pp   = PP_W'(p_q) * PP_W'(half);

  div_req_t           div_req;
  logic [DIV_W-1:0]   div_rem, div_dv;
  logic [DIVQ_W-1:0]  div_lo, div_q;
  logic               div_busy, div_done;
  logic               den_zero, sat_hi;
  logic [15:0]        alpha_w;

  assign den_zero = (den_q == '0);
  always_comb begin
    div_req.start = 1'b0;
    div_req.iters = CNT_W'(DIVQ_W);
    div_rem       = DIV_W'(n2_q >> DIVQ_W);
    div_lo        = n2_q[DIVQ_W-1:0];
    div_dv        = d2;
    if (state_q == S_AGO) begin
      div_req.start = !den_zero;
      div_req.iters = CNT_W'(16);
      div_rem       = DIV_W'(n1 >> 16);
      div_lo        = {n1[15:0], {(DIVQ_W-16){1'b0}}};
      div_dv        = d1;
    end else if (state_q == S_DGO) begin
      div_req.start = 1'b1;
    end
  end

  stfp_div #(.DW(DIV_W), .QW(DIVQ_W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .rem_init_i (div_rem),
    .lo_i       (div_lo),
    .divisor_i  (div_dv),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_q)
  );

  assign sat_hi  = |div_q[DIVQ_W-1:16];
  assign alpha_w = sat_hi ? 16'hFFFF : div_q[15:0];

  // reference limit check and saturating update
  logic signed [24:0] ref_ext, lim_ext;
  logic               beyond;
  logic signed [26:0] ref_sum;
  logic signed [23:0] ref_new, ref_clamp;
  assign ref_ext   = {ref_q[23], ref_q};
  assign lim_ext   = {2'b00, lim_q};
  assign beyond    = (ref_ext > lim_ext) || (-ref_ext > lim_ext);
  assign ref_clamp = (ref_q > 24'sd0) ? $signed({1'b0, lim_q}) : -$signed({1'b0, lim_q});
  assign ref_sum   = $signed({{3{ref_q[23]}}, ref_q}) + $signed({delta_q[DIVQ_W], delta_q});
  always_comb begin
    if (beyond) begin
      ref_new = ref_clamp;
    end else if (ref_sum > 27'sd8388607) begin
      ref_new = 24'sh7FFFFF;
    end else if (ref_sum < -27'sd8388608) begin
      ref_new = -24'sh800000;
    end else begin
      ref_new = ref_sum[23:0];
    end
  end

  // sequencer and control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tick_q      <= '0;
      prev_q      <= '0;
      ref_q       <= '0;
      refr_q      <= 1'b0;
      issue_q     <= 1'b0;
      mac_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < NumTerms; k++) begin
        eg_q[k] <= '0;
        cg_q[k] <= '0;
      end
    end else begin
      // the final step refills the slot itself when it frees
      if (out_take && state_q != S_FIN) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            refr_q  <= refr_now;
            tick_q  <= refr_now ? 8'd0 : tick_inc;
            issue_q <= 1'b1;
            state_q <= refr_now ? S_CHG : S_MAC;
          end
        end
        S_CHG:  state_q <= S_FUZE;
        S_FUZE: begin
          for (int k = 0; k < NumTerms; k++) eg_q[k] <= fuzz_g[k];
          prev_q  <= x_q;
          state_q <= S_FUZC;
        end
        S_FUZC: begin
          for (int k = 0; k < NumTerms; k++) cg_q[k] <= fuzz_g[k];
          state_q <= S_MAC;
        end
        S_MAC: begin
          mac_v_q <= issue_q;
          if (issue_q && i_q == 3'd6 && j_q == 3'd6) begin
            issue_q <= 1'b0;
          end
          if (!issue_q && !mac_v_q) begin
            state_q <= S_AGO;
          end
        end
        S_AGO:  state_q <= den_zero ? S_FIN : S_ADIV;
        S_ADIV: begin
          if (div_done) begin
            state_q <= (beyond || den_zero) ? S_FIN : S_MLO;
          end
        end
        S_MLO:  state_q <= S_MHI;
        S_MHI:  state_q <= S_DGO;
        S_DGO:  state_q <= S_DDIV;
        S_DDIV: begin
          if (div_done) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            ref_q       <= ref_new;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          x_q     <= error_value_i;
          i_q     <= '0;
          j_q     <= '0;
          den_q   <= '0;
          anum_q  <= '0;
          snum_q  <= '0;
          alpha_q <= '0;
          delta_q <= '0;
        end
      end
      S_CHG: change_q <= prod[ERROR_WIDTH+16:8];
      S_MAC: begin
        w_q <= w_d;
        a_q <= ALPHA_TAB[i_q][j_q];
        s_q <= step_level(i_q, j_q);
        if (issue_q) begin
          if (j_q == 3'd6) begin
            j_q <= '0;
            i_q <= i_q + 3'd1;
          end else begin
            j_q <= j_q + 3'd1;
          end
        end
        if (mac_v_q) begin
          den_q  <= den_q + DEN_W'(w_q);
          anum_q <= anum_q + wa;
          snum_q <= snum_q + ws;
        end
      end
      S_ADIV: begin
        if (div_done) begin
          alpha_q <= alpha_w;
          p_q     <= 24'(alpha_w) * 24'(og_q);
        end
      end
      S_MLO: n2_q <= N2_W'(pp);
      S_MHI: n2_q <= n2_q + (N2_W'(pp) << 19);
      S_DDIV: begin
        if (div_done) begin
          delta_q <= snum_q[SNUM_W-1] ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
        end
      end
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_ref_q  <= ref_new;
          out_gain_q <= alpha_q;
          out_refr_q <= refr_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign reference_o   = out_ref_q;
  assign tuning_gain_o = out_gain_q;
  assign refreshed_o   = out_refr_q;

  // a new result word only comes out of the final sequencer step
  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == S_FIN)
    else $error("result word raised outside the final step");

  // the divider never runs while the block is idle
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !div_busy)
    else $error("divider busy while idle");

  // tuning gain is bounded by the largest singleton times the largest gain
  a_gain_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> tuning_gain_o <= 16'd61440)
    else $error("tuning gain out of range");

endmodule
`default_nettype wire

/* verif/self_tuning_fuzzy_pi_controller_checker.sv */
// checker: tracks config writes, predicts each reference word and compares results
`timescale 1ns / 1ps
module self_tuning_fuzzy_pi_controller_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [stfp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [stfp_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic signed [15:0]                error_value_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  logic signed [23:0]                reference_i,
  input  logic [15:0]                       tuning_gain_i,
  input  logic                              refreshed_i,
  output int                                fail_count_o,
  output int                                pending_o
);
  import stfp_pkg::*;

  typedef struct {
    logic [23:0] reference;
    logic [15:0] tuning_gain;
    logic        refreshed;
  } tick_result_t;

  localparam int RULE_ALPHA [7][7] = '{
    '{5, 5, 4, 3, 2, 1, 1},
    '{5, 4, 3, 2, 1, 1, 1},
    '{4, 3, 2, 1, 1, 1, 2},
    '{3, 2, 1, 1, 1, 2, 3},
    '{3, 1, 1, 1, 2, 3, 4},
    '{1, 1, 1, 2, 3, 4, 5},
    '{1, 1, 2, 3, 4, 5, 5}
  };
  localparam int STEP_HUNDREDTHS [7] = '{-100, -66, -33, 0, 33, 66, 100};

  tick_result_t expected_words[$];

  longint gain_err_change, gain_alpha, gain_out, limit_ref, period_refresh;
  int     err_grade [7];
  int     chg_grade [7];
  longint held_error, ref_now;
  int     ticks;

  function automatic int ramp_q12(longint num, longint den);
    if (num <= 0) return 0;
    if (num >= den) return ONE_Q12;
    return int'((num * ONE_Q12) / den);
  endfunction

  function automatic int min_grade(int a, int b);
    return (a < b) ? a : b;
  endfunction

  function automatic void grade_terms(longint x, output int g [7]);
    g[0] = ramp_q12(-(x + BP2), BP3 - BP2);
    g[1] = min_grade(ramp_q12(x + BP3, BP3 - BP2), ramp_q12(-(x + BP1), BP2 - BP1));
    g[2] = min_grade(ramp_q12(x + BP2, BP2 - BP1), ramp_q12(-x, BP1));
    g[3] = min_grade(ramp_q12(x + BP1, BP1), ramp_q12(BP1 - x, BP1));
    g[4] = min_grade(ramp_q12(x, BP1), ramp_q12(BP2 - x, BP2 - BP1));
    g[5] = min_grade(ramp_q12(x - BP1, BP2 - BP1), ramp_q12(BP3 - x, BP3 - BP2));
    g[6] = ramp_q12(x - BP2, BP3 - BP2);
  endfunction

  // one control tick: refresh grades when due, infer alpha and the step
  function automatic tick_result_t advance_tick(logic signed [15:0] e);
    tick_result_t r;
    longint x, chg, prod, w, den, anum, snum, alpha, delta, per;
    int k;
    bit refr;
    x = e;
    den = 0; anum = 0; snum = 0; alpha = 0;
    per = (period_refresh == 0) ? 1 : period_refresh;
    ticks = (ticks + 1) & 8'hFF;
    refr = (ticks >= per);
    if (refr) begin
      prod = (x - held_error) * gain_err_change;
      chg = prod / 256;
      if (prod < 0 && (prod % 256) != 0) chg = chg - 1;
      ticks = 0;
      grade_terms(x, err_grade);
      grade_terms(chg, chg_grade);
      held_error = x;
    end
    for (int i = 0; i < 7; i++) begin
      for (int j = 0; j < 7; j++) begin
        w = longint'(err_grade[i]) * longint'(chg_grade[j]);
        k = i + j - 3;
        if (k < 0) k = 0;
        if (k > 6) k = 6;
        den += w;
        anum += w * RULE_ALPHA[i][j];
        snum += w * STEP_HUNDREDTHS[k];
      end
    end
    if (den > 0) alpha = (gain_alpha * ONE_Q12 * anum) / (5 * den);
    if (alpha > 65535) alpha = 65535;
    // magnitude beyond the limit: clamp by sign, no step this tick
    if (ref_now > limit_ref || -ref_now > limit_ref) begin
      ref_now = (ref_now > 0) ? limit_ref : -limit_ref;
    end else if (den > 0) begin
      delta = (alpha * gain_out * snum) / (100 * den);
      ref_now += delta;
      if (ref_now > 8388607) ref_now = 8388607;
      if (ref_now < -8388608) ref_now = -8388608;
    end
    r.reference = ref_now[23:0];
    r.tuning_gain = alpha[15:0];
    r.refreshed = refr;
    return r;
  endfunction

  assign pending_o = expected_words.size();

  always @(posedge clk_i or negedge rst_ni) begin
    tick_result_t want;
    if (!rst_ni) begin
      gain_err_change = ERR_GAIN_RST;
      gain_alpha = ALPHA_GAIN_RST;
      gain_out = OUT_GAIN_RST;
      limit_ref = REF_LIMIT_RST;
      period_refresh = PERIOD_RST;
      for (int i = 0; i < 7; i++) begin
        err_grade[i] = 0;
        chg_grade[i] = 0;
      end
      held_error = 0;
      ref_now = 0;
      ticks = 0;
      fail_count_o = 0;
      expected_words.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_ERR_GAIN:   gain_err_change = cfg_data_i[15:0];
          CFG_ALPHA_GAIN: gain_alpha = cfg_data_i[3:0];
          CFG_OUT_GAIN:   gain_out = cfg_data_i[7:0];
          CFG_REF_LIMIT:  limit_ref = cfg_data_i[22:0];
          CFG_PERIOD:     period_refresh = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("unexpected result word: ref %0d gain %0d refr %0b",
                     reference_i, tuning_gain_i, refreshed_i);
        end else begin
          want = expected_words.pop_front();
          if (reference_i !== want.reference || tuning_gain_i !== want.tuning_gain ||
              refreshed_i !== want.refreshed) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("mismatch: ref exp %0d got %0d, gain exp %0d got %0d, refr exp %0b got %0b",
                       $signed(want.reference), reference_i, want.tuning_gain, tuning_gain_i,
                       want.refreshed, refreshed_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) expected_words.push_back(advance_tick(error_value_i));
    end
  end

endmodule

/* verif/self_tuning_fuzzy_pi_controller_tb.sv */
// testbench top: error word stimulus, config phases, idling and verdict
`timescale 1ns / 1ps
module self_tuning_fuzzy_pi_controller_tb;
  import stfp_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 150;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic signed [15:0]     error_value_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic signed [23:0]     reference_o;
  logic [15:0]            tuning_gain_o;
  logic                   refreshed_o;

  int fail_count, pending, cycles;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic signed [15:0] walk_error = '0;

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  self_tuning_fuzzy_pi_controller dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .error_value_i,
    .out_valid_o, .out_stall_i, .reference_o, .tuning_gain_o, .refreshed_o
  );

  self_tuning_fuzzy_pi_controller_checker checker_inst (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .error_value_i,
    .out_valid_i(out_valid_o), .out_stall_i, .reference_i(reference_o),
    .tuning_gain_i(tuning_gain_o), .refreshed_i(refreshed_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver stalls at random, updated on the falling edge
  always @(negedge clk_i) begin
    out_stall_i = ($urandom_range(99) < recv_stall_pct);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("self_tuning_fuzzy_pi_controller_tb: done, errors");
      $finish;
    end
  end

  // offer one error word and hold it until the block takes it
  task automatic send_error(logic signed [15:0] e);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    error_value_i = e;
    forever begin
      #1;
      if (!in_stall_o) break;
      @(negedge clk_i);
    end
    @(posedge clk_i);
  endtask

  // drop valid, let all results drain, then give the block time to go idle
  task automatic wait_quiet();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val[CFG_DATA_W-1:0];
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // mostly slow drifting errors near the breakpoints, some jumps and noise
  function automatic logic signed [15:0] next_error();
    int r, d;
    r = $urandom_range(99);
    if (r < 70) begin
      d = $urandom_range(800) - 400;
      if (walk_error + d > 32767) walk_error = 16'sh7FFF;
      else if (walk_error + d < -32768) walk_error = 16'sh8000;
      else walk_error = 16'(walk_error + d);
    end else if (r < 85) begin
      walk_error = 16'($urandom_range(8192) - 4096);
    end else begin
      walk_error = 16'($urandom());
    end
    return walk_error;
  endfunction

  function automatic int unsigned pick(int unsigned lo, int unsigned hi);
    case ($urandom_range(3))
      0: return lo;
      1: return hi;
      default: return $urandom_range(hi, lo);
    endcase
  endfunction

  initial begin
    static logic signed [15:0] corner [23] = '{
      16'sd0, 16'sd32767, -16'sd32768, 16'sd768, -16'sd768, 16'sd1536, -16'sd1536,
      16'sd3072, -16'sd3072, 16'sd1, -16'sd1, 16'sd4096, -16'sd4096, 16'sd384,
      -16'sd384, 16'sd2304, -16'sd2304, 16'sd767, -16'sd1537, 16'sd1000,
      -16'sd200, 16'sd3071, 16'sh5555
    };
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: empty rule base until the first refresh on tick 20
    foreach (corner[i]) send_error(corner[i]);
    wait_quiet();

    // zero refresh period acts as one, zero alpha gain freezes the reference
    write_reg(CFG_PERIOD, 0);
    write_reg(CFG_ALPHA_GAIN, 0);
    send_error(16'sd2000);
    send_error(-16'sd2000);
    send_error(16'sd500);
    wait_quiet();

    // period lowered below the running count refreshes on the next tick
    write_reg(CFG_ALPHA_GAIN, 15);
    write_reg(CFG_OUT_GAIN, 255);
    write_reg(CFG_ERR_GAIN, 65535);
    write_reg(CFG_PERIOD, 50);
    repeat (6) send_error(16'sd3000);
    wait_quiet();
    write_reg(CFG_PERIOD, 3);
    send_error(-16'sd3000);
    send_error(16'sd100);
    wait_quiet();

    // reference beyond the limit gets clamped
    write_reg(CFG_REF_LIMIT, 0);
    send_error(16'sd1200);
    send_error(-16'sd1200);
    wait_quiet();
    write_reg(CFG_REF_LIMIT, 8388607);
    write_reg(CFG_ERR_GAIN, 0);
    write_reg(CFG_OUT_GAIN, 0);
    send_error(16'sd700);
    wait_quiet();

    // random phases with fresh settings, extremes among them
    for (int seg = 0; seg < 15; seg++) begin
      if (seg < 5) begin
        send_idle_pct = 30;
        recv_stall_pct = 55;
      end else if (seg < 10) begin
        send_idle_pct = 55;
        recv_stall_pct = 30;
      end else begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      write_reg(CFG_ERR_GAIN, pick(0, 65535));
      write_reg(CFG_ALPHA_GAIN, pick(0, 15));
      write_reg(CFG_OUT_GAIN, pick(0, 255));
      write_reg(CFG_REF_LIMIT, ($urandom_range(1)) ? pick(0, 8388607)
                                                   : $urandom_range(200000));
      write_reg(CFG_PERIOD, ($urandom_range(9) == 0) ? pick(0, 255) : $urandom_range(6));
      repeat (100) send_error(next_error());
      wait_quiet();
    end

    if (fail_count == 0) begin
      $display("self_tuning_fuzzy_pi_controller_tb: done, clean");
    end else begin
      $display("self_tuning_fuzzy_pi_controller_tb: done, errors");
    end
    $finish;
  end

endmodule
